@@ rtl/tcw_pkg.sv @@
// Shared types and constants for the text console writer.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int COL_W      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CMD_DEPTH  = 2;
    localparam int CMD_PTR_W  = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CMD_CNT_W  = $clog2(CMD_DEPTH + 1);

    localparam logic [1:0]  KIND_PUT   = 2'd0;
    localparam logic [1:0]  KIND_READ  = 2'd1;
    localparam logic [1:0]  KIND_WRITE = 2'd2;

    localparam logic [7:0]  CHAR_NUL   = 8'h00;
    localparam logic [7:0]  CHAR_LF    = 8'h0A;
    localparam logic [7:0]  CHAR_CR    = 8'h0D;
    localparam logic [7:0]  CHAR_SPACE = 8'h20;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  char_code;
        logic [10:0] cell_address;
        logic [15:0] cell_value;
    } request_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic [6:0]  cursor_column;
        logic [4:0]  cursor_row;
    } result_t;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_PUT,
        OP_READ,
        OP_WRITE
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t           op;
        logic              blank;
        logic [ADDR_W-1:0] addr;
        logic [15:0]       data;
        logic [6:0]        col;
        logic [4:0]        row;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_BLANK_RD,
        ST_BLANK_WR
    } back_state_t;

endpackage

`default_nettype wire

@@ rtl/tcw_front.sv @@
// Front end: accepts requests, tracks the cursor, turns each request into a command.
// Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcw_front
    import tcw_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire request_t request,
    input  wire logic     cmd_full,
    input  wire logic     init_done,
    output logic          cmd_push,
    output cmd_t          cmd
);

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic              accept;
    logic              new_row;
    logic              in_range;

    assign full     = cmd_full || !init_done;
    assign accept   = push && !full;
    assign cmd_push = accept;
    assign in_range = (32'(request.cell_address) < 32'(CELL_COUNT));

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        base_next = base_reg;
        new_row   = 1'b0;
        cmd.op    = OP_NOP;
        cmd.blank = 1'b0;
        cmd.addr  = ADDR_W'(request.cell_address);
        cmd.data  = request.cell_value;

        case (request.kind)
            KIND_PUT:
            begin
                cmd.data = {8'h00, request.char_code};
                if (request.char_code == CHAR_LF)
                begin
                    new_row = 1'b1;
                end
                else if (request.char_code == CHAR_CR)
                begin
                    col_next = '0;
                end
                else if (request.char_code != CHAR_NUL)
                begin
                    cmd.op   = OP_PUT;
                    cmd.addr = ADDR_W'(int'(base_reg) + int'(col_reg));
                    if (col_reg == COL_W'(COLUMNS - 1))
                    begin
                        new_row = 1'b1;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end
            KIND_READ:
            begin
                cmd.op = in_range ? OP_READ : OP_NOP;
            end
            KIND_WRITE:
            begin
                cmd.op = in_range ? OP_WRITE : OP_NOP;
            end
            default:
            begin
                cmd.op = OP_NOP;
            end
        endcase

        if (new_row)
        begin
            col_next = '0;
            if (row_reg == ROW_W'(ROWS - 1))
            begin
                row_next  = '0;
                base_next = '0;
                cmd.blank = 1'b1;
            end
            else
            begin
                row_next  = row_reg + 1'b1;
                base_next = ADDR_W'(int'(base_reg) + COLUMNS);
            end
        end

        cmd.col = 7'(col_next);
        cmd.row = 5'(row_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            base_reg <= '0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            base_reg <= base_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/tcw_cmd_fifo.sv @@
// Short command queue between the front end and the screen engine.
// Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcw_cmd_fifo
    import tcw_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire cmd_t wr_cmd,
    output logic      cmd_full,
    input  wire logic rd_en,
    output logic      rd_valid,
    output cmd_t      rd_cmd
);

    cmd_t                 entry_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_CNT_W-1:0] count_reg, count_next;
    logic                 do_wr;
    logic                 do_rd;

    assign cmd_full = (count_reg == CMD_CNT_W'(CMD_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !cmd_full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

`default_nettype wire

@@ rtl/tcw_back.sv @@
// Screen engine: owns the cell memory, runs commands, blank sweeps and the reset clear.
// Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcw_back
    import tcw_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    input  wire cmd_t cmd_in,
    output logic      cmd_pop,
    output logic      init_done,
    output logic      empty,
    input  wire logic pop,
    output result_t   result
);

    logic [15:0]       screen_mem [CELL_COUNT];

    back_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              res_valid_reg, res_valid_next;
    result_t           res_reg;
    cmd_t              cmd_reg;
    logic [15:0]       mem_q_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic              start;
    logic              res_load;
    logic              idx_last;

    assign init_done = (state_reg != ST_CLEAR);
    assign empty     = !res_valid_reg;
    assign result    = res_reg;
    assign idx_last  = (idx_reg == ADDR_W'(CELL_COUNT - 1));
    assign start     = cmd_valid && (!res_valid_reg || pop);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (idx_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = cmd_reg.blank ? ST_BLANK_RD : ST_IDLE;
            end
            ST_BLANK_RD:
            begin
                state_next = ST_BLANK_WR;
            end
            ST_BLANK_WR:
            begin
                state_next = idx_last ? ST_IDLE : ST_BLANK_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = idx_reg;
        cmd_pop   = 1'b0;
        res_load  = 1'b0;
        idx_next  = idx_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                idx_next = idx_reg + 1'b1;
            end
            ST_IDLE:
            begin
                cmd_pop   = start;
                mem_re    = start;
                mem_raddr = cmd_in.addr;
            end
            ST_EXEC:
            begin
                mem_waddr = cmd_reg.addr;
                if (cmd_reg.op == OP_PUT)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = {mem_q_reg[15:8], cmd_reg.data[7:0]};
                end
                else if (cmd_reg.op == OP_WRITE)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = cmd_reg.data;
                end
                res_load = !cmd_reg.blank;
                idx_next = '0;
            end
            ST_BLANK_RD:
            begin
                mem_re = 1'b1;
            end
            ST_BLANK_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = {mem_q_reg[15:8], CHAR_SPACE};
                res_load  = idx_last;
                idx_next  = idx_reg + 1'b1;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (pop && res_valid_reg)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd_in;
        end
        if (res_load)
        begin
            res_reg.read_data     <= (cmd_reg.op == OP_READ) ? mem_q_reg : 16'h0000;
            res_reg.cursor_column <= cmd_reg.col;
            res_reg.cursor_row    <= cmd_reg.row;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            mem_q_reg <= screen_mem[mem_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/text_console_writer.sv @@
// The queue registers each accepted request; the engine reads its cell in ST_IDLE, then
// writes it for a put or write and loads the result in ST_EXEC, taking no new request until
// it is back in ST_IDLE and any held result is popped. A line feed or wrap past the last row
// adds a blank sweep that reads, then rewrites, each of the 2000 cells. Reset: asynchronous,
// active low; the engine then zeroes all 2000 cells, one a cycle, with full held high.
// Top level: front end, command queue and screen engine; depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer
    import tcw_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire request_t request,
    input  wire logic     pop,
    output logic          empty,
    output result_t       result
);

    logic cmd_full;
    logic cmd_push;
    cmd_t front_cmd;
    logic queue_valid;
    cmd_t queue_cmd;
    logic queue_pop;
    logic init_done;

    tcw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .request   (request),
        .cmd_full  (cmd_full),
        .init_done (init_done),
        .cmd_push  (cmd_push),
        .cmd       (front_cmd)
    );

    tcw_cmd_fifo u_cmd_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cmd_push),
        .wr_cmd   (front_cmd),
        .cmd_full (cmd_full),
        .rd_en    (queue_pop),
        .rd_valid (queue_valid),
        .rd_cmd   (queue_cmd)
    );

    tcw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_valid),
        .cmd_in    (queue_cmd),
        .cmd_pop   (queue_pop),
        .init_done (init_done),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

`default_nettype wire

@@ tb/sv/text_console_writer_tb.sv @@
// Self-checking testbench for text_console_writer: directed and random traffic,
// with results checked against a cycle-free screen and cursor predictor.
// Depends on tcw_pkg and the text_console_writer RTL.
`timescale 1ns / 1ps

module text_console_writer_tb;
    import tcw_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [7:0] CHAR_HIGH   = 8'hFF;
    localparam logic [7:0] CHAR_A      = 8'h41;
    localparam int ITEM_TARGET = 2000;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 10;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     push = 1'b0;
    logic     full;
    request_t req_bus = '0;
    logic     pop = 1'b0;
    logic     empty;
    result_t  res_bus;

    text_console_writer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .request (req_bus),
        .pop     (pop),
        .empty   (empty),
        .result  (res_bus)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // screen and cursor as the block should hold them
    logic [15:0] screen_model [CELL_COUNT];
    int          cursor_col;
    int          cursor_row;
    result_t     expected_results [$];

    int  cycle_count = 0;
    int  items_sent = 0;
    int  results_checked = 0;
    int  mismatches = 0;
    int  blank_sweeps = 0;
    int  reads_sent = 0;
    bit  tx_steady = 1'b0;
    bit  rx_steady = 1'b0;

    function automatic request_t make_req(logic [1:0] kind, logic [7:0] ch,
                                          logic [10:0] addr, logic [15:0] val);
        request_t r;
        r.kind         = kind;
        r.char_code    = ch;
        r.cell_address = addr;
        r.cell_value   = val;
        return r;
    endfunction

    function automatic void next_line();
        cursor_col = 0;
        if (cursor_row == ROWS - 1)
        begin
            cursor_row = 0;
            blank_sweeps++;
            foreach (screen_model[k])
                screen_model[k] = {screen_model[k][15:8], CHAR_SPACE};
        end
        else
            cursor_row++;
    endfunction

    function automatic void put_char(logic [7:0] ch);
        int pos;
        if (ch == CHAR_NUL)
            return;
        if (ch == CHAR_LF)
            next_line();
        else if (ch == CHAR_CR)
            cursor_col = 0;
        else
        begin
            pos = cursor_row * COLUMNS + cursor_col;
            screen_model[pos] = {screen_model[pos][15:8], ch};
            cursor_col++;
            if (cursor_col >= COLUMNS)
                next_line();
        end
    endfunction

    function automatic result_t predict_console(request_t req);
        result_t r;
        r.read_data = '0;
        case (req.kind)
            KIND_PUT:
                put_char(req.char_code);
            KIND_READ:
                if (req.cell_address < CELL_COUNT)
                    r.read_data = screen_model[req.cell_address];
            KIND_WRITE:
                if (req.cell_address < CELL_COUNT)
                    screen_model[req.cell_address] = req.cell_value;
            default: ;
        endcase
        r.cursor_column = cursor_col[6:0];
        r.cursor_row    = cursor_row[4:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (tx_steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_request(input request_t req);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        req_bus <= req;
        @(posedge clk);
        while (full)
            @(posedge clk);
        expected_results.push_back(predict_console(req));
        items_sent++;
        if (req.kind == KIND_READ)
            reads_sent++;
    endtask

    function automatic void report_mismatch(string what, result_t want, result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display(
                "mismatch (%s) cycle %0d: want rd=%h col=%0d row=%0d got rd=%h col=%0d row=%0d",
                what, cycle_count, want.read_data, want.cursor_column, want.cursor_row,
                got.read_data, got.cursor_column, got.cursor_row);
    endfunction

    function automatic void check_result(result_t got);
        result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch("no transfer pending", '0, got);
            return;
        end
        want = expected_results.pop_front();
        results_checked++;
        if (got.read_data !== want.read_data)
            report_mismatch("read_data", want, got);
        else if (got.cursor_column !== want.cursor_column)
            report_mismatch("cursor_column", want, got);
        else if (got.cursor_row !== want.cursor_row)
            report_mismatch("cursor_row", want, got);
    endfunction

    // result side: random pop with short and long stalls
    initial
    begin
        int stall_left;
        int r;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                check_result(res_bus);
            if (rx_steady)
                pop <= 1'b1;
            else if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 75)
                    pop <= 1'b1;
                else if (r < 95)
                    pop <= 1'b0;
                else
                begin
                    pop <= 1'b0;
                    stall_left = $urandom_range(10, 60);
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d transfers still expected",
                 cycle_count, expected_results.size());
        $display("text_console_writer_tb: FAIL");
        $finish;
    end

    task automatic test_host_access_and_put();
        send_request(make_req(KIND_READ, 8'h00, 11'd0, 16'h0000));
        send_request(make_req(KIND_READ, 8'h00, 11'd1999, 16'h0000));
        send_request(make_req(KIND_READ, 8'h00, 11'd2047, 16'h0000));
        send_request(make_req(KIND_WRITE, 8'h00, 11'd0, 16'hFFFF));
        send_request(make_req(KIND_WRITE, 8'h00, 11'd2047, 16'h1234));
        send_request(make_req(KIND_READ, 8'h00, 11'd2047, 16'h0000));
        send_request(make_req(KIND_PUT, CHAR_HIGH, 11'd0, 16'h0000));
        send_request(make_req(KIND_PUT, CHAR_NUL, 11'd2047, 16'hFFFF));
        send_request(make_req(KIND_WRITE, 8'h00, 11'd1, 16'hA500));
        send_request(make_req(KIND_PUT, CHAR_A, 11'd0, 16'h0000));
        send_request(make_req(KIND_PUT, CHAR_CR, 11'd0, 16'h0000));
        send_request(make_req(KIND_READ, 8'h00, 11'd0, 16'h0000));
        send_request(make_req(KIND_READ, 8'h00, 11'd1, 16'h0000));
        send_request(make_req(KIND_UNUSED, 8'hFF, 11'd2047, 16'hFFFF));
        send_request(make_req(KIND_WRITE, 8'h00, 11'd1999, 16'h7E00));
    endtask

    // line feeds to the last row, then one more forces the blank sweep
    task automatic test_screen_blank();
        while (cursor_row != ROWS - 1)
            send_request(make_req(KIND_PUT, CHAR_LF, 11'd0, 16'h0000));
        send_request(make_req(KIND_PUT, CHAR_LF, 11'd0, 16'h0000));
        send_request(make_req(KIND_READ, 8'h00, 11'd0, 16'h0000));
        send_request(make_req(KIND_READ, 8'h00, 11'd1999, 16'h0000));
    endtask

    function automatic request_t random_noise();
        return make_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                        11'($urandom_range(0, 2047)), 16'($urandom_range(0, 65535)));
    endfunction

    function automatic logic [7:0] random_text_char();
        logic [7:0] ch;
        do
            ch = 8'($urandom_range(1, 255));
        while (ch == CHAR_LF || ch == CHAR_CR);
        return ch;
    endfunction

    // mostly text lines ending in CR LF, with host reads and writes mixed in
    task automatic test_random_traffic();
        int len;
        int r;
        int phase_mark;
        phase_mark = items_sent;
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent - phase_mark >= 200)
            begin
                phase_mark = items_sent;
                tx_steady  = ($urandom_range(0, 3) == 0);
                rx_steady  = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 9) < 7)
            begin
                len = $urandom_range(0, 100);
                repeat (len)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 8)
                        send_request(make_req(KIND_READ, 8'($urandom_range(0, 255)),
                            11'($urandom_range(0, CELL_COUNT - 1)), 16'($urandom_range(0, 65535))));
                    else if (r < 12)
                        send_request(make_req(KIND_WRITE, 8'($urandom_range(0, 255)),
                            11'($urandom_range(0, CELL_COUNT - 1)), 16'($urandom_range(0, 65535))));
                    else
                        send_request(make_req(KIND_PUT, random_text_char(),
                            11'($urandom_range(0, 2047)), 16'($urandom_range(0, 65535))));
                end
                send_request(make_req(KIND_PUT, CHAR_CR, 11'd0, 16'h0000));
                send_request(make_req(KIND_PUT, CHAR_LF, 11'd0, 16'h0000));
            end
            else
            begin
                repeat ($urandom_range(1, 12))
                    send_request(random_noise());
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial
    begin
        foreach (screen_model[k])
            screen_model[k] = '0;
        cursor_col = 0;
        cursor_row = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_host_access_and_put();
        test_screen_blank();
        test_random_traffic();

        push <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d transfers (%0d cell reads), %0d results checked, %0d mismatches",
                 items_sent, reads_sent, results_checked, mismatches);
        $display("predicted %0d screen blank sweeps in %0d cycles", blank_sweeps, cycle_count);
        if (mismatches == 0)
            $display("text_console_writer_tb: PASS");
        else
            $display("text_console_writer_tb: FAIL");
        $finish;
    end

endmodule

@@ text_console_writer.f @@
rtl/tcw_pkg.sv
rtl/tcw_front.sv
rtl/tcw_cmd_fifo.sv
rtl/tcw_back.sv
rtl/text_console_writer.sv
tb/sv/text_console_writer_tb.sv
